// File: sv/dnve_pkg.sv
// ----------------------------------------------------------------------------
// dnve_pkg
// Shared types, character constants and helpers for the DN value escaper.
// ----------------------------------------------------------------------------
package dnve_pkg;

    // Character constants
    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_QUOTE     = 8'h22;
    localparam logic [7:0] C_HASH      = 8'h23;
    localparam logic [7:0] C_PLUS      = 8'h2B;
    localparam logic [7:0] C_COMMA     = 8'h2C;
    localparam logic [7:0] C_SEMI      = 8'h3B;
    localparam logic [7:0] C_LESS      = 8'h3C;
    localparam logic [7:0] C_EQUAL     = 8'h3D;
    localparam logic [7:0] C_GREATER   = 8'h3E;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_TILDE     = 8'h7E;
    localparam logic [7:0] C_DIGIT_0   = 8'h30;
    localparam logic [7:0] C_LETTER_A  = 8'h41;

    // Reset value of the compatibility register
    localparam logic COMPAT_RESET = 1'b1;

    // Queue between classifier and emitter
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Input word
    typedef struct packed {
        logic [7:0] value_byte;
        logic       first_of_value;
        logic       last_of_value;
        logic       hex_dump;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } t_out_word;

    // Classified byte: up to three characters and index of the last one
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      last_idx;
    } t_plan;

    // Uppercase hex digit for a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
        logic [7:0] res;
        if (nibble < 4'd10) begin
            res = C_DIGIT_0 + {4'd0, nibble};
        end else begin
            res = C_LETTER_A + {4'd0, nibble} - 8'd10;
        end
        return res;
    endfunction

endpackage

// File: sv/dnve_classify.sv
// ----------------------------------------------------------------------------
// dnve_classify
// Front end: decides the escape form of one byte and builds its plan.
// ----------------------------------------------------------------------------
module dnve_classify
    import dnve_pkg::*;
(
    input  t_in_word i_word,
    input  logic     i_compat_mode,
    output t_plan    o_plan
);

    logic [7:0] c;
    logic       special;
    logic       printable;

    // Flag characters that always need a backslash, plus '#' and '=' in compat mode
    always_comb begin
        c         = i_word.value_byte;
        special   = (c inside {C_BACKSLASH, C_QUOTE, C_PLUS, C_COMMA,
                               C_SEMI, C_LESS, C_GREATER}) ||
                    (i_compat_mode && (c inside {C_HASH, C_EQUAL}));
        printable = (c >= C_SPACE) && (c <= C_TILDE);
    end

    // Build the character sequence, rules in priority order
    always_comb begin
        o_plan = '0;
        if (i_word.hex_dump) begin
            if (i_word.first_of_value) begin
                o_plan.chars[0] = C_HASH;
                o_plan.chars[1] = hex_digit(c[7:4]);
                o_plan.chars[2] = hex_digit(c[3:0]);
                o_plan.last_idx = 2'd2;
            end else begin
                o_plan.chars[0] = hex_digit(c[7:4]);
                o_plan.chars[1] = hex_digit(c[3:0]);
                o_plan.last_idx = 2'd1;
            end
        end else if (i_word.first_of_value && (c == C_SPACE || c == C_HASH)) begin
            o_plan.chars[0] = C_BACKSLASH;
            o_plan.chars[1] = c;
            o_plan.last_idx = 2'd1;
        end else if (i_word.last_of_value && c == C_SPACE) begin
            o_plan.chars[0] = C_BACKSLASH;
            o_plan.chars[1] = C_SPACE;
            o_plan.last_idx = 2'd1;
        end else if (special) begin
            o_plan.chars[0] = C_BACKSLASH;
            o_plan.chars[1] = c;
            o_plan.last_idx = 2'd1;
        end else if (printable) begin
            o_plan.chars[0] = c;
            o_plan.last_idx = 2'd0;
        end else begin
            o_plan.chars[0] = C_BACKSLASH;
            o_plan.chars[1] = hex_digit(c[7:4]);
            o_plan.chars[2] = hex_digit(c[3:0]);
            o_plan.last_idx = 2'd2;
        end
    end

endmodule

// File: sv/dnve_queue.sv
// ----------------------------------------------------------------------------
// dnve_queue
// Short queue of classified plans between front end and emitter.
// ----------------------------------------------------------------------------
module dnve_queue
    import dnve_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_en,
    input  t_plan i_wr_plan,
    output logic  o_full,
    input  logic  i_rd_en,
    output t_plan o_rd_plan,
    output logic  o_empty
);

    t_plan                r_slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]    r_count,  n_count;
    logic                 do_wr;
    logic                 do_rd;

    assign o_full    = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;
    assign o_rd_plan = r_slots[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = do_wr ? r_wr_ptr + QUEUE_AW'(1) : r_wr_ptr;
        n_rd_ptr = do_rd ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_count  = r_count + (QUEUE_AW+1)'(do_wr) - (QUEUE_AW+1)'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the plan
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_slots[r_wr_ptr] <= i_wr_plan;
        end
    end

endmodule

// File: sv/dnve_emit.sv
// ----------------------------------------------------------------------------
// dnve_emit
// Back end: walks the head plan into a register, one char per cycle unless held.
// ----------------------------------------------------------------------------
module dnve_emit
    import dnve_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_plan     i_plan,
    input  logic      i_plan_empty,
    output logic      o_plan_take,
    output t_out_word o_word,
    output logic      o_empty,
    input  logic      i_pop
);

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_out_word  r_out;
    logic       load;
    logic       at_last;

    // Load a character when the output register is free or being drained
    assign load        = !i_plan_empty && (!r_out_valid || i_pop);
    assign at_last     = (r_idx == i_plan.last_idx);
    assign o_plan_take = load && at_last;
    assign o_word      = r_out;
    assign o_empty     = !r_out_valid;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (load) begin
            n_idx       = at_last ? 2'd0 : r_idx + 2'd1;
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_char <= i_plan.chars[r_idx];
            r_out.out_last <= at_last;
        end
    end

endmodule

// File: sv/dn_value_escaper_top.sv
// ----------------------------------------------------------------------------
// dn_value_escaper_top
// Escapes distinguished-name attribute value bytes into string-form characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive i_in_word and raise push; a word is taken
//   at a clock edge with push high and full low.
//   Output side is a queue: while empty is low, o_out_word holds the oldest
//   character; pop high at a clock edge takes it. out_last marks the final
//   character of each input byte.
//   Config: i_cfg_compat_mode is written when i_cfg_valid and o_cfg_ready
//   are high (ready is always high); write only while the block is idle.
// Timing:
//   A taken byte is stored in the plan queue, and its characters are then
//   registered one by one in the emitter's output register. The emitter
//   gives one character per cycle while pop keeps that register drained;
//   a byte makes 1 to 3 characters (plain, escaped, or backslash plus two hex
//   digits). A four-entry plan queue lets input be taken while results wait.
// Reset and stall:
//   Synchronous active-low reset empties the queue and output register and
//   sets compat mode to 1. When pop stays low, the output holds, the queue
//   fills and full is raised; nothing is lost.
// ----------------------------------------------------------------------------
module dn_value_escaper_top
    import dnve_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_word  i_in_word,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_compat_mode
);

    logic  r_compat_mode;
    t_plan front_plan;
    t_plan head_plan;
    logic  q_empty;
    logic  q_take;

    assign o_cfg_ready = 1'b1;

    // Compatibility register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compat_mode <= COMPAT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_compat_mode <= i_cfg_compat_mode;
        end
    end

    dnve_classify u_classify (
        .i_word        (i_in_word),
        .i_compat_mode (r_compat_mode),
        .o_plan        (front_plan)
    );

    dnve_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (push),
        .i_wr_plan (front_plan),
        .o_full    (full),
        .i_rd_en   (q_take),
        .o_rd_plan (head_plan),
        .o_empty   (q_empty)
    );

    dnve_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan       (head_plan),
        .i_plan_empty (q_empty),
        .o_plan_take  (q_take),
        .o_word       (o_out_word),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule

// File: sim/tb_dn_value_escaper_top.sv
// ----------------------------------------------------------------------------
// tb_dn_value_escaper_top
// Self-checking bench for the DN attribute value escaper.
// Drives input bytes through the push/full queue port and drains characters
// through the empty/pop port with random gaps on both sides. A scoreboard
// predicts the escaped characters of every accepted byte and compares them,
// in order, with the characters that leave the block. The run covers both
// compat settings, hex-dump values, edge bytes, a long receiver stall that
// fills the block, and a sender pause until the block drains.
// ----------------------------------------------------------------------------
module tb_dn_value_escaper_top
    import dnve_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    // Predict escaped characters and check them against the block
    class escape_scoreboard;
        t_out_word pending_chars[$];
        logic      compat;
        int        errors;
        int        reports;
        int        bytes_taken;
        int        chars_checked;

        function new();
            pending_chars.delete();
            compat        = COMPAT_RESET;
            errors        = 0;
            reports       = 0;
            bytes_taken   = 0;
            chars_checked = 0;
        endfunction

        function void set_compat(input logic value);
            compat = value;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        function logic [7:0] nibble_char(input logic [3:0] nib);
            logic [7:0] ch;
            if (nib < 4'd10) begin
                ch = 8'h30 + {4'd0, nib};
            end else begin
                ch = 8'h37 + {4'd0, nib};
            end
            return ch;
        endfunction

        function logic needs_backslash(input logic [7:0] c);
            logic hit;
            hit = (c == C_BACKSLASH) || (c == C_QUOTE) || (c == C_PLUS) ||
                  (c == C_COMMA) || (c == C_SEMI) || (c == C_LESS) ||
                  (c == C_GREATER);
            if (compat && ((c == C_HASH) || (c == C_EQUAL))) begin
                hit = 1'b1;
            end
            return hit;
        endfunction

        // Expand one accepted byte into the characters it must produce
        function void note_input(input t_in_word w);
            logic [7:0] seq[$];
            logic [7:0] c;
            t_out_word  exp_word;
            c = w.value_byte;
            if (w.hex_dump) begin
                if (w.first_of_value) begin
                    seq.push_back(C_HASH);
                end
                seq.push_back(nibble_char(c[7:4]));
                seq.push_back(nibble_char(c[3:0]));
            end else if (w.first_of_value && ((c == C_SPACE) || (c == C_HASH))) begin
                seq.push_back(C_BACKSLASH);
                seq.push_back(c);
            end else if (w.last_of_value && (c == C_SPACE)) begin
                seq.push_back(C_BACKSLASH);
                seq.push_back(C_SPACE);
            end else if (needs_backslash(c)) begin
                seq.push_back(C_BACKSLASH);
                seq.push_back(c);
            end else if ((c >= C_SPACE) && (c <= C_TILDE)) begin
                seq.push_back(c);
            end else begin
                seq.push_back(C_BACKSLASH);
                seq.push_back(nibble_char(c[7:4]));
                seq.push_back(nibble_char(c[3:0]));
            end
            for (int k = 0; k < seq.size(); k++) begin
                exp_word.out_char = seq[k];
                exp_word.out_last = (k == seq.size() - 1);
                pending_chars.push_back(exp_word);
            end
            bytes_taken++;
        endfunction

        // Compare one character leaving the block with the oldest expectation
        function void check_result(input t_out_word got);
            t_out_word exp_word;
            chars_checked++;
            if (pending_chars.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("ERROR: unexpected char %h last %b", got.out_char, got.out_last);
                end
                return;
            end
            exp_word = pending_chars.pop_front();
            if ((got.out_char !== exp_word.out_char) ||
                (got.out_last !== exp_word.out_last)) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("ERROR: char exp %h got %h, last exp %b got %b",
                             exp_word.out_char, got.out_char,
                             exp_word.out_last, got.out_last);
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    t_in_word  i_in_word;
    logic      full;
    logic      empty;
    logic      pop;
    t_out_word o_out_word;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic      i_cfg_compat_mode;

    escape_scoreboard board;
    logic no_idle;
    logic hold_req;
    logic hold_active;
    int   cycles;
    int   full_stalls;
    int   settings_done;

    dn_value_escaper_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .i_in_word         (i_in_word),
        .full              (full),
        .empty             (empty),
        .pop               (pop),
        .o_out_word        (o_out_word),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_compat_mode (i_cfg_compat_mode)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Hold the receiver off for a long stretch on request
    initial begin
        hold_active = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
                hold_req    = 1'b0;
            end
        end
    end

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    // Drain characters with random stalls and check each one
    task automatic run_receiver();
        int wait_left;
        wait_left = idle_draw();
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                board.check_result(o_out_word);
                wait_left = idle_draw();
            end
            if (hold_active || (wait_left > 0)) begin
                pop <= 1'b0;
                if (wait_left > 0) begin
                    wait_left--;
                end
            end else begin
                pop <= 1'b1;
            end
        end
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        run_receiver();
    end

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input t_in_word w);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_word <= w;
        do begin
            @(posedge i_clk);
            if (full) begin
                full_stalls++;
            end
        end while (full);
        board.note_input(w);
    endtask

    task automatic send_fields(input logic [7:0] value, input logic first,
                               input logic last, input logic hex);
        t_in_word w;
        w.value_byte     = value;
        w.first_of_value = first;
        w.last_of_value  = last;
        w.hex_dump       = hex;
        send_word(w);
    endtask

    // Drop push and wait until every expected character has left the block
    task automatic let_block_drain();
        push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_compat(input logic value);
        i_cfg_valid       <= 1'b1;
        i_cfg_compat_mode <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_compat(value);
        settings_done++;
    endtask

    // Bias bytes toward the characters the escaping rules care about
    function automatic logic [7:0] pick_value_byte();
        logic [7:0] specials [7];
        int         sel;
        specials = '{C_BACKSLASH, C_QUOTE, C_PLUS, C_COMMA, C_SEMI, C_LESS, C_GREATER};
        sel = $urandom_range(0, 9);
        case (sel)
            0: return C_SPACE;
            1: return C_HASH;
            2: return C_EQUAL;
            3: return specials[$urandom_range(0, 6)];
            4: return 8'($urandom_range(0, 31));
            5: return 8'($urandom_range(127, 255));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    // Mostly well-formed values with random content, some loose words
    task automatic send_random_values(input int n_items);
        int       sent;
        int       len;
        logic     hex;
        t_in_word w;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 5) == 0) begin
                w.value_byte     = 8'($urandom_range(0, 255));
                w.first_of_value = 1'($urandom_range(0, 1));
                w.last_of_value  = 1'($urandom_range(0, 1));
                w.hex_dump       = 1'($urandom_range(0, 1));
                send_word(w);
                sent++;
            end else begin
                len = $urandom_range(1, 8);
                hex = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < len; k++) begin
                    w.value_byte     = pick_value_byte();
                    w.first_of_value = (k == 0);
                    w.last_of_value  = (k == len - 1);
                    w.hex_dump       = hex;
                    send_word(w);
                    sent++;
                end
            end
        end
    endtask

    // Main sequence
    initial begin
        board             = new();
        no_idle           = 1'b0;
        hold_req          = 1'b0;
        full_stalls       = 0;
        settings_done     = 0;
        i_rst_n           <= 1'b0;
        push              <= 1'b0;
        i_in_word         <= '0;
        pop               <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_compat_mode <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: leading, trailing and special characters in compat mode
        write_compat(1'b1);
        send_fields(C_SPACE,     1'b1, 1'b0, 1'b0);
        send_fields(C_SPACE,     1'b0, 1'b0, 1'b0);
        send_fields(C_SPACE,     1'b0, 1'b1, 1'b0);
        send_fields(C_SPACE,     1'b1, 1'b1, 1'b0);
        send_fields(C_HASH,      1'b1, 1'b1, 1'b0);
        send_fields(C_HASH,      1'b0, 1'b0, 1'b0);
        send_fields(C_EQUAL,     1'b0, 1'b0, 1'b0);
        send_fields(C_BACKSLASH, 1'b0, 1'b0, 1'b0);
        send_fields(C_QUOTE,     1'b0, 1'b0, 1'b0);
        send_fields(C_PLUS,      1'b0, 1'b0, 1'b0);
        send_fields(C_COMMA,     1'b0, 1'b0, 1'b0);
        send_fields(C_SEMI,      1'b0, 1'b0, 1'b0);
        send_fields(C_LESS,      1'b0, 1'b0, 1'b0);
        send_fields(C_GREATER,   1'b0, 1'b1, 1'b0);
        send_fields(8'h00,       1'b1, 1'b0, 1'b0);
        send_fields(8'h1F,       1'b0, 1'b0, 1'b0);
        send_fields(C_TILDE,     1'b0, 1'b0, 1'b0);
        send_fields(8'h7F,       1'b0, 1'b0, 1'b0);
        send_fields(8'hFF,       1'b0, 1'b1, 1'b0);
        send_fields(8'hA5,       1'b1, 1'b0, 1'b1);
        send_fields(8'h3C,       1'b0, 1'b0, 1'b1);
        send_fields(8'hFF,       1'b0, 1'b1, 1'b1);
        let_block_drain();

        // Directed: mid-value '#' and '=' pass through without compat mode
        write_compat(1'b0);
        send_fields(C_HASH,  1'b0, 1'b0, 1'b0);
        send_fields(C_EQUAL, 1'b0, 1'b1, 1'b0);
        send_fields(C_HASH,  1'b1, 1'b0, 1'b0);
        send_fields(8'h00,   1'b1, 1'b1, 1'b1);
        let_block_drain();

        // Random values, compat off
        send_random_values(25);
        let_block_drain();

        // Hold the receiver while the sender keeps pushing, so full rises
        write_compat(1'b1);
        hold_req = 1'b1;
        no_idle  = 1'b1;
        send_random_values(20);
        no_idle  = 1'b0;
        send_random_values(10);
        let_block_drain();

        // Pause the sender mid-phase until the block has drained
        write_compat(1'($urandom_range(0, 1)));
        send_random_values(20);
        let_block_drain();
        send_random_values(20);
        let_block_drain();

        // Back-to-back stretch with no idling on either side
        write_compat(1'b0);
        no_idle = 1'b1;
        send_random_values(25);
        no_idle = 1'b0;
        let_block_drain();

        write_compat(1'b1);
        send_random_values(30);
        let_block_drain();

        // Wait out the block's latency, then settle the verdict
        repeat (8) @(posedge i_clk);
        if (board.pending() != 0) begin
            board.errors++;
            $display("ERROR: %0d expected chars never arrived", board.pending());
        end
        $display("Run covered %0d input bytes and %0d output chars over %0d compat writes,",
                 board.bytes_taken, board.chars_checked, settings_done);
        $display("with %0d input cycles stalled by full; %0d errors.",
                 full_stalls, board.errors);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/dnve_pkg.sv
sv/dnve_classify.sv
sv/dnve_queue.sv
sv/dnve_emit.sv
sv/dn_value_escaper_top.sv
sim/tb_dn_value_escaper_top.sv
